[rtl/pd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pd_pkg: shared types and constants of the percent decoder
// Holds the character codes, the decoder phase codes, the hex digit value
// function and the structs passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package pd_pkg;

    // Character codes.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    // Decoder phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PERCENT = 2'd1;
    localparam logic [1:0] PH_HIGH    = 2'd2;

    // Decoder state carried from one beat to the next.
    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] high_nibble;
    } pd_state_t;

    // One result beat.
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
    } pd_result_t;

    // Digit value of a character: x-'0' for decimal digits, otherwise
    // lowercase(x)-'a'+10 wrapped to 8 bits, with no check that x is hex.
    function automatic logic [7:0] hex_value(input logic [7:0] x);
        logic [7:0] c;
        c = x;
        if (x >= CH_ZERO && x <= CH_NINE) begin
            return x - CH_ZERO;
        end
        if (x >= CH_UPPER_A && x <= CH_UPPER_Z) begin
            c = x + CASE_FOLD;
        end
        return c - CH_LOWER_A + HEX_ALPHA_OFFSET;
    endfunction

endpackage
`default_nettype wire

[rtl/pd_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pd_step: combinational step of the percent decoder
// Given the current decoder state and one input byte, produces the next
// state and the result beat (if any) that the byte causes.
// ----------------------------------------------------------------------------
module pd_step (
    input  wire pd_pkg::pd_state_t  state_in,
    input  wire logic [7:0]         in_byte,
    input  wire logic               is_last,
    output pd_pkg::pd_state_t       state_out,
    output pd_pkg::pd_result_t      result
);

    logic [7:0] digit;
    logic       is_pct;

    assign digit  = pd_pkg::hex_value(in_byte);
    assign is_pct = (in_byte == pd_pkg::CH_PERCENT);

    // Phase walk: idle -> percent seen -> high digit held -> idle.
    always_comb begin
        state_out = state_in;
        result    = '0;
        case (state_in.phase)
            pd_pkg::PH_HIGH: begin
                // Second digit completes the escape.
                state_out.phase       = pd_pkg::PH_IDLE;
                state_out.high_nibble = 4'd0;
                result.valid          = 1'b1;
                result.out_byte       = {state_in.high_nibble, 4'd0} + digit;
                result.has_byte       = 1'b1;
                result.end_of_string  = is_last;
            end
            pd_pkg::PH_PERCENT: begin
                if (!is_last) begin
                    state_out.high_nibble = digit[3:0];
                    state_out.phase       = pd_pkg::PH_HIGH;
                end else begin
                    // The pending percent is dropped; the last byte is
                    // handled as an ordinary byte.
                    state_out.phase       = pd_pkg::PH_IDLE;
                    state_out.high_nibble = 4'd0;
                    result.valid          = 1'b1;
                    result.end_of_string  = 1'b1;
                    if (!is_pct) begin
                        result.out_byte = in_byte;
                        result.has_byte = 1'b1;
                    end
                end
            end
            default: begin
                // Idle, and the unused phase code treated the same way.
                state_out.phase = pd_pkg::PH_IDLE;
                if (is_pct) begin
                    if (is_last) begin
                        state_out.high_nibble = 4'd0;
                        result.valid          = 1'b1;
                        result.end_of_string  = 1'b1;
                    end else begin
                        state_out.phase = pd_pkg::PH_PERCENT;
                    end
                end else begin
                    result.valid         = 1'b1;
                    result.out_byte      = in_byte;
                    result.has_byte      = 1'b1;
                    result.end_of_string = is_last;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/percent_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// percent_decoder: streaming URL percent decoder
// Decodes a byte stream one beat per cycle while the receiver keeps up, and emits decoded bytes.
// ----------------------------------------------------------------------------
// The decoder takes one input beat per clock cycle and delivers its result
// in the next cycle from an output register; the input is accepted whenever
// that register is empty or is being drained in the same cycle, so a full
// stream runs at one beat per cycle while m_tready stays high. A percent
// sign and the first digit after it produce no result beat; the second
// digit produces the decoded byte. The last beat of a string (s_tlast)
// always produces a result with m_tlast set; m_tuser low marks a result
// that carries no byte (a dangling percent sign), and then m_tdata is zero.
// ----------------------------------------------------------------------------
module percent_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input stream.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // is_last
    // Result stream.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // has_byte
    output logic            m_tlast    // end_of_string
);

    pd_pkg::pd_state_t  state_reg;
    pd_pkg::pd_state_t  state_next;
    pd_pkg::pd_result_t step_result;

    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic       m_has_reg;
    logic       m_end_reg;
    logic       in_beat;

    // Accept while the output register is free or emptying this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;

    pd_step u_step (
        .state_in  (state_reg),
        .in_byte   (s_tdata),
        .is_last   (s_tlast),
        .state_out (state_next),
        .result    (step_result)
    );

    // Decoder state advances on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_beat) begin
            state_reg <= state_next;
        end
    end

    // Output register: loaded by a beat that yields a result, else drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_beat) begin
            m_valid_reg <= step_result.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && step_result.valid) begin
            m_byte_reg <= step_result.out_byte;
            m_has_reg  <= step_result.has_byte;
            m_end_reg  <= step_result.end_of_string;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_end_reg;

    // A result without a byte only ever comes from the last beat of a string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("byte-less result without end of string");

    // A result without a byte carries zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("byte-less result with nonzero data");

    // The decoder is idle after the last beat of a string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg.phase == pd_pkg::PH_IDLE))
        else $error("decoder not idle after end of string");

    // A last beat always yields a result beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && m_tlast))
        else $error("last beat produced no end-of-string result");

endmodule
`default_nettype wire

[tb/tb_percent_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_percent_decoder: self-checking testbench of the percent decoder
// A queue of encoded strings feeds a stream driver. Every accepted input beat
// runs through a local decoder model that queues the expected result beats.
// A monitor compares each result beat with the oldest expected one. Both
// sides idle at random, the receiver stalls for long stretches, and the
// sender waits for the decoder to drain at chosen points.
// ----------------------------------------------------------------------------
module tb_percent_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // One encoded byte waiting to be sent. When drain_first is set, the
    // driver holds it back until every expected result beat has arrived.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain_first;
    } enc_item_t;

    // One decoded result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
    } dec_beat_t;

    localparam int NUM_RANDOM_ITEMS = 430;
    localparam int HOLD_CYCLES      = 40;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    enc_item_t  enc_q[$];
    dec_beat_t  decoded_q[$];

    // Decoder model state.
    logic [1:0] model_phase = pd_pkg::PH_IDLE;
    logic [3:0] model_high  = 4'h0;

    int tx_count  = 0;
    int rx_count  = 0;
    int err_count = 0;
    int hold_left = 0;
    int hold_done = 0;

    percent_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Digit value: decimal digits count from '0'; anything else is folded to
    // lowercase and counted from 'a' plus ten, wrapping at 8 bits.
    function automatic logic [7:0] digit_value(input logic [7:0] ch);
        logic [7:0] folded;
        if (ch >= pd_pkg::CH_ZERO && ch <= pd_pkg::CH_NINE) begin
            return ch - pd_pkg::CH_ZERO;
        end
        folded = (ch >= pd_pkg::CH_UPPER_A && ch <= pd_pkg::CH_UPPER_Z)
               ? ch + pd_pkg::CASE_FOLD : ch;
        return folded - pd_pkg::CH_LOWER_A + pd_pkg::HEX_ALPHA_OFFSET;
    endfunction

    // Advance the decoder model by one input beat and queue its result, if any.
    function automatic void decode_beat(input logic [7:0] ch, input logic last);
        dec_beat_t  res;
        logic [7:0] dv;
        res = '0;
        dv  = digit_value(ch);
        if (model_phase == pd_pkg::PH_HIGH) begin
            // Second digit completes the escape.
            res.data    = {model_high, 4'h0} + dv;
            res.has     = 1'b1;
            res.eos     = last;
            model_phase = pd_pkg::PH_IDLE;
            model_high  = 4'h0;
            decoded_q.push_back(res);
        end else if (model_phase == pd_pkg::PH_PERCENT && !last) begin
            // First digit is held; no result yet.
            model_high  = dv[3:0];
            model_phase = pd_pkg::PH_HIGH;
        end else if (model_phase == pd_pkg::PH_PERCENT) begin
            // The string ends right after a percent: drop the percent and
            // treat the final byte as a plain one.
            model_phase = pd_pkg::PH_IDLE;
            model_high  = 4'h0;
            res.eos     = 1'b1;
            if (ch != pd_pkg::CH_PERCENT) begin
                res.data = ch;
                res.has  = 1'b1;
            end
            decoded_q.push_back(res);
        end else begin
            model_phase = pd_pkg::PH_IDLE;
            if (ch == pd_pkg::CH_PERCENT && last) begin
                model_high = 4'h0;
                res.eos    = 1'b1;
                decoded_q.push_back(res);
            end else if (ch == pd_pkg::CH_PERCENT) begin
                model_phase = pd_pkg::PH_PERCENT;
            end else begin
                res.data = ch;
                res.has  = 1'b1;
                res.eos  = last;
                decoded_q.push_back(res);
            end
        end
    endfunction

    // Idle percentages: the sender idles lightly and the receiver heavily
    // first, then the other way round, then neither idles.
    function automatic int send_idle_pct();
        return (tx_count < 150) ? 14 : (tx_count < 300) ? 65 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (tx_count < 150) ? 65 : (tx_count < 300) ? 14 : 0;
    endfunction

    // Input driver: predicts on every accepted beat, then loads the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_beat(s_tdata, s_tlast);
                tx_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (enc_q.size() > 0
                        && !(enc_q[0].drain_first && decoded_q.size() != 0)
                        && (hold_left > 0
                            || $urandom_range(0, 99) >= send_idle_pct())) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= enc_q[0].data;
                    s_tlast  <= enc_q[0].last;
                    void'(enc_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, plus two long hold-offs while the
    // sender keeps offering beats so that the decoder backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if ((hold_done == 0 && rx_count >= 60)
                || (hold_done == 1 && rx_count >= 320)) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Result monitor: every accepted beat is checked against the oldest
    // expected beat, field by field.
    always @(posedge aclk) begin
        dec_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            rx_count++;
            if (decoded_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("ERROR: unexpected result beat data=%02h has=%0b eos=%0b",
                             m_tdata, m_tuser, m_tlast);
                end
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.data || m_tuser !== want.has
                        || m_tlast !== want.eos) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("ERROR: result %0d: data %02h/%02h has %0b/%0b eos %0b/%0b",
                                 rx_count, m_tdata, want.data, m_tuser, want.has,
                                 m_tlast, want.eos);
                    end
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] ch, input logic last, input bit drain);
        enc_item_t it;
        it.data        = ch;
        it.last        = last;
        it.drain_first = drain;
        enc_q.push_back(it);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int k;
        k = $urandom_range(0, 21);
        if (k < 10) begin
            return pd_pkg::CH_ZERO + 8'(k);
        end else if (k < 16) begin
            return pd_pkg::CH_LOWER_A + 8'(k - 10);
        end
        return pd_pkg::CH_UPPER_A + 8'(k - 16);
    endfunction

    // One random string: mostly plain bytes and well-formed escapes, with
    // some escapes carrying arbitrary digits, stray percents and cut tails.
    task automatic add_random_string(input bit drain, inout int planned);
        logic [7:0] bytes[$];
        int         len;
        int         kind;
        len = $urandom_range(1, 12);
        while (bytes.size() < len) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                bytes.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 85) begin
                bytes.push_back(pd_pkg::CH_PERCENT);
                bytes.push_back(rand_hex_char());
                bytes.push_back(rand_hex_char());
            end else if (kind < 93) begin
                bytes.push_back(pd_pkg::CH_PERCENT);
                bytes.push_back(8'($urandom_range(0, 255)));
                bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                bytes.push_back(pd_pkg::CH_PERCENT);
            end
        end
        // Sometimes cut an escape short at the end of the string.
        if (bytes.size() > len && $urandom_range(0, 1) == 1) begin
            while (bytes.size() > len) begin
                void'(bytes.pop_back());
            end
        end
        foreach (bytes[i]) begin
            add_byte(bytes[i], i == bytes.size() - 1, drain && i == 0);
        end
        planned += bytes.size();
    endtask

    // Stimulus and end of run.
    initial begin
        int planned;
        int n_str;
        planned = 0;
        n_str   = 0;

        // Extremes passed through.
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // Escapes with digits, lowercase and uppercase; second digit last.
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte("4", 1'b0, 1'b0);
        add_byte("1", 1'b0, 1'b0);
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte("f", 1'b0, 1'b0);
        add_byte("F", 1'b1, 1'b0);
        // Percent as the last byte.
        add_byte(pd_pkg::CH_PERCENT, 1'b1, 1'b0);
        // Last byte right after a percent: plain byte, then a percent.
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte("x", 1'b1, 1'b0);
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte(pd_pkg::CH_PERCENT, 1'b1, 1'b0);
        // Percent signs used as digits.
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte(pd_pkg::CH_PERCENT, 1'b1, 1'b0);
        // Non-hex digits that wrap, then a high byte to end the string.
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte("G", 1'b0, 1'b0);
        add_byte("g", 1'b0, 1'b0);
        add_byte(8'h80, 1'b1, 1'b0);
        // Escape with a decimal first digit and a zero byte, ending the string, as its second digit.
        add_byte(pd_pkg::CH_PERCENT, 1'b0, 1'b0);
        add_byte("9", 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);

        // Random strings; the sender drains the decoder now and then.
        while (planned < NUM_RANDOM_ITEMS) begin
            add_random_string(n_str % 40 == 0, planned);
            n_str++;
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (enc_q.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (decoded_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (err_count == 0 && decoded_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
